>>> rtl/bpaf_pkg.sv
// package for the battery peak average filter
// register indexes, reset values and field widths; no dependencies

package bpaf_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COUNT_W  = 8;
  localparam int INDEX_W  = 8;
  localparam int CFG_W    = 16;

  localparam int GROUP_LEN_DEFAULT = 8;

  localparam logic [SAMPLE_W-1:0] WINDOW_RESET  = 16'd200;
  localparam logic [COUNT_W-1:0]  ACCEPT_RESET  = 8'd3;
  localparam logic [SAMPLE_W-1:0] EJECT_RESET   = 16'd3000;
  localparam logic                REMOVE_RESET  = 1'b0;

  typedef enum logic [INDEX_W-1:0] {
    REG_WINDOW    = 8'd0,
    REG_ACCEPT    = 8'd1,
    REG_EJECT     = 8'd2,
    REG_REMOVABLE = 8'd3
  } reg_index_t;

endpackage

>>> rtl/battery_peak_average_filter.sv
// battery peak average filter, top level
// depends on bpaf_pkg for register indexes, reset values and widths
//
// usage: one 16-bit millivolt sample enters per word on the s_ stream, and
// every accepted word gives exactly one result word on the m_ stream holding
// a valid flag and the current filtered voltage. the first sample after reset
// is published directly; later samples pass a window test around the last
// result (or a run of outliers) and feed a running group maximum whose sums
// are averaged after GROUP_LEN group peaks. in removable mode a confirmed
// insert or eject crossing publishes the sample and restarts the groups.
// path: an accepted input word goes from the input register, through one pass
// of compare, max, add and reciprocal multiply, into the result register.
// throughput: one word per cycle while m_tready stays high.
// the cfg channel is always ready; registers should be written while idle.
// reset (rst, synchronous) restores the register defaults and filter state
// and empties both stages. when m_tready is low the result register holds
// and the input register keeps one more word, after which s_tready drops.

module battery_peak_average_filter
  import bpaf_pkg::*;
#(
  parameter int GROUP_LEN = GROUP_LEN_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [15:0]         s_tdata,   // sample_mv[15:0]
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [23:0]         m_tdata,   // result_valid[0], filtered_mv[16:1], zero pad
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [INDEX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]    cfg_data
);

  localparam int CNT_W = (GROUP_LEN > 1) ? $clog2(GROUP_LEN) : 1;
  localparam int SUM_W = SAMPLE_W + CNT_W;
  localparam int SHIFT = SUM_W + CNT_W;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << SHIFT) + 64'(GROUP_LEN) - 64'd1) / 64'(GROUP_LEN);
  localparam logic [SUM_W:0] RECIP = RECIP_FULL[SUM_W:0];
  localparam logic [CNT_W-1:0] LAST_FILL = CNT_W'(GROUP_LEN - 1);

  // configuration
  logic [SAMPLE_W-1:0] window_mv;
  logic [COUNT_W-1:0]  accept_count;
  logic [SAMPLE_W-1:0] eject_mv;
  logic                removable;

  // filter state
  logic                first_pending;
  logic                inserted_flag;
  logic [COUNT_W-1:0]  action_count;
  logic [COUNT_W-1:0]  outlier_count;
  logic [CNT_W-1:0]    group_fill;
  logic [SAMPLE_W-1:0] group_peak;
  logic [CNT_W-1:0]    peak_fill;
  logic [SUM_W-1:0]    peak_sum;
  logic [SAMPLE_W-1:0] last_result;

  logic                first_pending_next;
  logic                inserted_flag_next;
  logic [COUNT_W-1:0]  action_count_next;
  logic [COUNT_W-1:0]  outlier_count_next;
  logic [CNT_W-1:0]    group_fill_next;
  logic [SAMPLE_W-1:0] group_peak_next;
  logic [CNT_W-1:0]    peak_fill_next;
  logic [SUM_W-1:0]    peak_sum_next;
  logic [SAMPLE_W-1:0] last_result_next;
  logic                valid_next;

  // stages
  logic                in_vld;
  logic [SAMPLE_W-1:0] in_sample;
  logic                out_flag;
  logic [SAMPLE_W-1:0] out_mv;
  logic                advance;

  // datapath
  logic                crossing;
  logic [COUNT_W-1:0]  action_inc;
  logic [COUNT_W-1:0]  outlier_inc;
  logic                in_window;
  logic                take;
  logic [SAMPLE_W-1:0] peak_new;
  logic [SUM_W-1:0]    sum_new;
  logic [2*SUM_W:0]    product;
  logic [SAMPLE_W-1:0] average;

  assign cfg_ready = 1'b1;
  assign advance   = !m_tvalid || m_tready;
  assign s_tready  = !in_vld || advance;
  assign m_tdata   = {7'd0, out_mv, out_flag};

  always_ff @(posedge clk) begin
    if (rst) begin
      window_mv    <= WINDOW_RESET;
      accept_count <= ACCEPT_RESET;
      eject_mv     <= EJECT_RESET;
      removable    <= REMOVE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WINDOW:    window_mv    <= cfg_data;
        REG_ACCEPT:    accept_count <= cfg_data[COUNT_W-1:0];
        REG_EJECT:     eject_mv     <= cfg_data;
        REG_REMOVABLE: removable    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    crossing    = removable && ((in_sample < eject_mv) == inserted_flag);
    action_inc  = action_count + COUNT_W'(1);
    outlier_inc = outlier_count + COUNT_W'(1);
    in_window   = ({1'b0, in_sample} <= {1'b0, last_result} + {1'b0, window_mv}) &&
                  ({1'b0, in_sample} + {1'b0, window_mv} >= {1'b0, last_result});
    peak_new    = (in_sample > group_peak) ? in_sample : group_peak;
    sum_new     = peak_sum + SUM_W'(peak_new);
    product     = (2*SUM_W+1)'(sum_new) * (2*SUM_W+1)'(RECIP);
    average     = product[SHIFT +: SAMPLE_W];
  end

  always_comb begin
    first_pending_next = first_pending;
    inserted_flag_next = inserted_flag;
    action_count_next  = action_count;
    outlier_count_next = outlier_count;
    group_fill_next    = group_fill;
    group_peak_next    = group_peak;
    peak_fill_next     = peak_fill;
    peak_sum_next      = peak_sum;
    last_result_next   = last_result;
    valid_next         = 1'b0;
    take               = 1'b0;
    if (first_pending) begin
      first_pending_next = 1'b0;
      last_result_next   = in_sample;
      valid_next         = 1'b1;
    end else if (crossing) begin
      action_count_next = action_inc;
      if (action_inc > accept_count) begin
        action_count_next  = '0;
        inserted_flag_next = !inserted_flag;
        group_fill_next    = '0;
        group_peak_next    = '0;
        peak_fill_next     = '0;
        peak_sum_next      = '0;
        last_result_next   = in_sample;
        valid_next         = 1'b1;
      end
    end else begin
      action_count_next = '0;
      if (in_window) begin
        outlier_count_next = '0;
        take               = 1'b1;
      end else begin
        outlier_count_next = outlier_inc;
        if (outlier_inc >= accept_count) begin
          outlier_count_next = '0;
          take               = 1'b1;
        end
      end
    end
    if (take) begin
      group_peak_next = peak_new;
      group_fill_next = group_fill + CNT_W'(1);
      if (group_fill == LAST_FILL) begin
        group_fill_next = '0;
        group_peak_next = '0;
        peak_sum_next   = sum_new;
        peak_fill_next  = peak_fill + CNT_W'(1);
        if (peak_fill == LAST_FILL) begin
          peak_fill_next   = '0;
          peak_sum_next    = '0;
          last_result_next = average;
          valid_next       = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld        <= 1'b0;
      m_tvalid      <= 1'b0;
      first_pending <= 1'b1;
      inserted_flag <= 1'b0;
      action_count  <= '0;
      outlier_count <= '0;
      group_fill    <= '0;
      group_peak    <= '0;
      peak_fill     <= '0;
      peak_sum      <= '0;
      last_result   <= '0;
    end else begin
      if (s_tready) begin
        in_vld <= s_tvalid;
      end
      if (advance) begin
        m_tvalid <= in_vld;
      end
      if (in_vld && advance) begin
        first_pending <= first_pending_next;
        inserted_flag <= inserted_flag_next;
        action_count  <= action_count_next;
        outlier_count <= outlier_count_next;
        group_fill    <= group_fill_next;
        group_peak    <= group_peak_next;
        peak_fill     <= peak_fill_next;
        peak_sum      <= peak_sum_next;
        last_result   <= last_result_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_sample <= s_tdata;
    end
    if (in_vld && advance) begin
      out_flag <= valid_next;
      out_mv   <= last_result_next;
    end
  end

  a_group_fill_range: assert property (@(posedge clk) disable iff (rst)
    (group_fill <= LAST_FILL) && (peak_fill <= LAST_FILL))
    else $error("group counters out of range");

  a_first_publishes: assert property (@(posedge clk) disable iff (rst)
    (in_vld && advance && first_pending) |=> (m_tvalid && m_tdata[0]))
    else $error("first sample not published");

  a_first_clears_once: assert property (@(posedge clk) disable iff (rst)
    $fell(first_pending) |-> $past(in_vld && advance))
    else $error("first flag cleared without a sample");

  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !$past(in_vld && advance) && !$past(rst) |-> $stable(last_result))
    else $error("result changed without a sample");

endmodule
